>>> rtl/bfdr_pkg.sv
// shared types and codes for the banked framebuffer dirty refresh block
package bfdr_pkg;

    localparam int ROWS_PER_PAGE = 8;
    localparam int STORE_ADDR_W  = 10;

    localparam logic [2:0] OP_SET_PIXEL = 3'd0;
    localparam logic [2:0] OP_GET_PIXEL = 3'd1;
    localparam logic [2:0] OP_FILL      = 3'd2;
    localparam logic [2:0] OP_MARK_AREA = 3'd3;
    localparam logic [2:0] OP_START     = 3'd4;
    localparam logic [2:0] OP_NEXT_BYTE = 3'd5;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_PAGE   = 2'd1;
    localparam logic [1:0] KIND_COLUMN = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] PHASE_PAGE   = 2'd0;
    localparam logic [1:0] PHASE_COLUMN = 2'd1;
    localparam logic [1:0] PHASE_DATA   = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] col;
        logic [5:0] row;
        logic [6:0] col_end;
        logic [5:0] row_end;
        logic       pixel_on;
        logic [7:0] fill_byte;
    } bfdr_in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_value;
        logic       pixel_bit;
        logic       last;
    } bfdr_out_t;

endpackage

>>> rtl/bfdr_ram.sv
// generic single write port, single read port ram with registered read
module bfdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 504,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/banked_framebuffer_dirty_refresh_core.sv
// Monochrome page framebuffer with a dirty rectangle and a byte-wise refresh stream.
// The input channel (s_valid, s_ready, s_data) carries one operation per transaction:
// set, clear or read a pixel, fill the buffer, mark an area dirty, start a refresh,
// or pull the next refresh byte. Every operation yields exactly one result on the
// m_valid, m_ready, m_data channel; kind tells a data byte, a set-page command,
// a set-column command or nothing apart, and last flags the final refresh byte.
// The store is read in the accept cycle; the read data is modified, written back and
// turned into a result in the execute state that follows. That read-modify-write on
// the store keeps s_ready low until the result is registered. A fill sweeps the store,
// writing the fill byte to all PAGE_COUNT*PANEL_COLUMNS bytes (504 by default).
// After reset the same sweep clears the store to zero; s_ready stays low meanwhile.
// When the receiver stalls, the result waits in the output register; the next
// transaction is still accepted and holds in the execute cycle until the output
// register frees up, so nothing is lost or repeated.
module banked_framebuffer_dirty_refresh_core #(
    parameter int PANEL_COLUMNS = 84,
    parameter int PANEL_ROWS    = 48,
    parameter int PAGE_COUNT    = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bfdr_pkg::bfdr_in_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bfdr_pkg::bfdr_out_t m_data
);
    import bfdr_pkg::*;

    localparam int DEPTH = PAGE_COUNT * PANEL_COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [6:0]    COL_LAST   = 7'(PANEL_COLUMNS - 1);
    localparam logic [5:0]    ROW_LAST   = 6'(PANEL_ROWS - 1);
    localparam logic [2:0]    PAGE_LAST  = 3'(PAGE_COUNT - 1);
    localparam logic [AW-1:0] ADDR_LAST  = AW'(DEPTH - 1);

    localparam logic [1:0] ST_SWEEP = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    function automatic logic [AW-1:0] store_addr(input logic [2:0] page,
                                                 input logic [6:0] col);
        logic [STORE_ADDR_W-1:0] full;
        full = STORE_ADDR_W'(page) * STORE_ADDR_W'(PANEL_COLUMNS) + STORE_ADDR_W'(col);
        return full[AW-1:0];
    endfunction

    function automatic logic pixel_ok(input logic [6:0] col, input logic [5:0] row);
        return ({1'b0, col} < 8'(PANEL_COLUMNS))
            && ({1'b0, row} < 7'(PANEL_ROWS))
            && ({1'b0, row[5:3]} < 4'(PAGE_COUNT));
    endfunction

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic [7:0]    sweep_data_reg, sweep_data_next;
    bfdr_in_t      in_reg, in_next;
    logic          m_valid_reg, m_valid_next;
    bfdr_out_t     m_data_reg, m_data_next;

    logic [6:0] dcol_min_reg, dcol_min_next;
    logic [6:0] dcol_max_reg, dcol_max_next;
    logic [5:0] drow_min_reg, drow_min_next;
    logic [5:0] drow_max_reg, drow_max_next;

    logic       active_reg, active_next;
    logic [6:0] col_lo_reg, col_lo_next;
    logic [6:0] col_hi_reg, col_hi_next;
    logic [2:0] page_reg, page_next;
    logic [2:0] page_end_reg, page_end_next;
    logic [1:0] phase_reg, phase_next;
    logic [6:0] col_reg, col_next;

    logic          accept, out_free, ok;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [7:0]    rd_data, wr_data, mask;
    logic [6:0]    chi;
    logic [2:0]    first_page, last_page;

    bfdr_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(wr_addr),
        .wdata(wr_data),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign rd_en    = accept;
    assign rd_addr  = (s_data.op == OP_NEXT_BYTE) ? store_addr(page_reg, col_reg)
                                                  : store_addr(s_data.row[5:3], s_data.col);
    assign ok       = pixel_ok(in_reg.col, in_reg.row);
    assign mask     = 8'(1) << in_reg.row[2:0];

    // dirty window clamped to the panel, latched into the cursor on start
    assign chi        = (dcol_max_reg > COL_LAST) ? COL_LAST : dcol_max_reg;
    assign first_page = drow_min_reg[5:3];
    assign last_page  = (drow_max_reg[5:3] > PAGE_LAST) ? PAGE_LAST : drow_max_reg[5:3];

    always_comb begin
        state_next      = state_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        sweep_data_next = sweep_data_reg;
        in_next         = in_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        dcol_min_next   = dcol_min_reg;
        dcol_max_next   = dcol_max_reg;
        drow_min_next   = drow_min_reg;
        drow_max_next   = drow_max_reg;
        active_next     = active_reg;
        col_lo_next     = col_lo_reg;
        col_hi_next     = col_hi_reg;
        page_next       = page_reg;
        page_end_next   = page_end_reg;
        phase_next      = phase_reg;
        col_next        = col_reg;
        wr_en           = 1'b0;
        wr_addr         = store_addr(in_reg.row[5:3], in_reg.col);
        wr_data         = in_reg.pixel_on ? (rd_data | mask) : (rd_data & ~mask);

        unique case (state_reg)
            ST_SWEEP: begin
                wr_en   = 1'b1;
                wr_addr = sweep_cnt_reg;
                wr_data = sweep_data_reg;
                if (sweep_cnt_reg == ADDR_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    sweep_cnt_next = sweep_cnt_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    in_next    = s_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.kind      = KIND_NONE;
                    m_data_next.out_value = 8'd0;
                    m_data_next.pixel_bit = 1'b0;
                    m_data_next.last      = 1'b0;
                    state_next            = ST_IDLE;
                    unique case (in_reg.op)
                        OP_SET_PIXEL: begin
                            wr_en = ok;
                        end
                        OP_GET_PIXEL: begin
                            m_data_next.pixel_bit = ok && rd_data[in_reg.row[2:0]];
                        end
                        OP_FILL: begin
                            dcol_min_next   = 7'd0;
                            drow_min_next   = 6'd0;
                            if (COL_LAST > dcol_max_reg) dcol_max_next = COL_LAST;
                            if (ROW_LAST > drow_max_reg) drow_max_next = ROW_LAST;
                            sweep_cnt_next  = '0;
                            sweep_data_next = in_reg.fill_byte;
                            state_next      = ST_SWEEP;
                        end
                        OP_MARK_AREA: begin
                            if (in_reg.col < dcol_min_reg)     dcol_min_next = in_reg.col;
                            if (in_reg.col_end > dcol_max_reg) dcol_max_next = in_reg.col_end;
                            if (in_reg.row < drow_min_reg)     drow_min_next = in_reg.row;
                            if (in_reg.row_end > drow_max_reg) drow_max_next = in_reg.row_end;
                        end
                        OP_START: begin
                            dcol_min_next = COL_LAST;
                            dcol_max_next = 7'd0;
                            drow_min_next = ROW_LAST;
                            drow_max_next = 6'd0;
                            phase_next    = PHASE_PAGE;
                            if (dcol_min_reg > chi || first_page > last_page
                                    || drow_min_reg > drow_max_reg) begin
                                active_next   = 1'b0;
                                col_lo_next   = 7'd0;
                                col_hi_next   = 7'd0;
                                page_next     = 3'd0;
                                page_end_next = 3'd0;
                                col_next      = 7'd0;
                            end else begin
                                active_next   = 1'b1;
                                col_lo_next   = dcol_min_reg;
                                col_hi_next   = chi;
                                page_next     = first_page;
                                page_end_next = last_page;
                                col_next      = dcol_min_reg;
                            end
                        end
                        OP_NEXT_BYTE: begin
                            if (active_reg) begin
                                if (phase_reg == PHASE_PAGE) begin
                                    m_data_next.kind      = KIND_PAGE;
                                    m_data_next.out_value = 8'(page_reg);
                                    phase_next            = PHASE_COLUMN;
                                end else if (phase_reg == PHASE_COLUMN) begin
                                    m_data_next.kind      = KIND_COLUMN;
                                    m_data_next.out_value = 8'(col_lo_reg);
                                    phase_next            = PHASE_DATA;
                                    col_next              = col_lo_reg;
                                end else begin
                                    m_data_next.kind      = KIND_DATA;
                                    m_data_next.out_value = rd_data;
                                    if (col_reg >= col_hi_reg) begin
                                        if (page_reg >= page_end_reg) begin
                                            // final byte: cursor back to idle
                                            m_data_next.last = 1'b1;
                                            active_next      = 1'b0;
                                            col_lo_next      = 7'd0;
                                            col_hi_next      = 7'd0;
                                            page_next        = 3'd0;
                                            page_end_next    = 3'd0;
                                            phase_next       = PHASE_PAGE;
                                            col_next         = 7'd0;
                                        end else begin
                                            page_next  = page_reg + 3'd1;
                                            phase_next = PHASE_PAGE;
                                        end
                                    end else begin
                                        col_next = col_reg + 7'd1;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            sweep_cnt_reg  <= '0;
            sweep_data_reg <= 8'd0;
            m_valid_reg    <= 1'b0;
            dcol_min_reg   <= 7'd0;
            dcol_max_reg   <= 7'd0;
            drow_min_reg   <= 6'd0;
            drow_max_reg   <= 6'd0;
            active_reg     <= 1'b0;
            col_lo_reg     <= 7'd0;
            col_hi_reg     <= 7'd0;
            page_reg       <= 3'd0;
            page_end_reg   <= 3'd0;
            phase_reg      <= PHASE_PAGE;
            col_reg        <= 7'd0;
        end else begin
            state_reg      <= state_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            sweep_data_reg <= sweep_data_next;
            m_valid_reg    <= m_valid_next;
            dcol_min_reg   <= dcol_min_next;
            dcol_max_reg   <= dcol_max_next;
            drow_min_reg   <= drow_min_next;
            drow_max_reg   <= drow_max_next;
            active_reg     <= active_next;
            col_lo_reg     <= col_lo_next;
            col_hi_reg     <= col_hi_next;
            page_reg       <= page_next;
            page_end_reg   <= page_end_next;
            phase_reg      <= phase_next;
            col_reg        <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    property p_no_accept_in_sweep;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == ST_SWEEP) |-> !s_ready;
    endproperty
    a_no_accept_in_sweep: assert property (p_no_accept_in_sweep)
        else $error("transaction accepted during store sweep");

    property p_cursor_col_in_window;
        @(posedge aclk) disable iff (!aresetn)
            active_reg |-> (col_reg <= col_hi_reg && col_hi_reg <= COL_LAST);
    endproperty
    a_cursor_col_in_window: assert property (p_cursor_col_in_window)
        else $error("refresh column outside latched window");

    property p_cursor_page_in_range;
        @(posedge aclk) disable iff (!aresetn)
            active_reg |-> (page_reg <= page_end_reg && page_end_reg <= PAGE_LAST);
    endproperty
    a_cursor_page_in_range: assert property (p_cursor_page_in_range)
        else $error("refresh page beyond last page");

    property p_last_only_on_data;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && m_data.last) |-> (m_data.kind == KIND_DATA);
    endproperty
    a_last_only_on_data: assert property (p_last_only_on_data)
        else $error("last flag on a non-data result");

    property p_last_ends_refresh;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == ST_EXEC && out_free && in_reg.op == OP_NEXT_BYTE
             && active_reg && phase_reg == PHASE_DATA && col_reg >= col_hi_reg
             && page_reg >= page_end_reg) |=> !active_reg;
    endproperty
    a_last_ends_refresh: assert property (p_last_ends_refresh)
        else $error("cursor still active after final byte");
`endif

endmodule

>>> bench/tb_banked_framebuffer_dirty_refresh_core.sv
// testbench for the banked framebuffer dirty refresh core: directed table, then random traffic
module tb_banked_framebuffer_dirty_refresh_core;
    import bfdr_pkg::*;

    localparam int PANEL_COLUMNS   = 84;
    localparam int PANEL_ROWS      = 48;
    localparam int PAGE_COUNT      = 6;
    localparam int STORE_SIZE      = PAGE_COUNT * PANEL_COLUMNS;
    localparam int RANDOM_ITEMS    = 1250;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 16;
    localparam int MAX_REPORTS     = 10;

    // opcodes the block treats as no-ops
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        bfdr_in_t  item;
        bit        typed;
        bfdr_out_t reply;
    } plan_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    bfdr_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    bfdr_out_t m_data;

    // behavioral copy of the panel
    logic [7:0] frame_mem [STORE_SIZE];
    logic [6:0] dirty_c_lo, dirty_c_hi;
    logic [5:0] dirty_r_lo, dirty_r_hi;
    bit         scan_on;
    int         scan_lo, scan_hi, scan_page, scan_page_end, scan_col;
    logic [1:0] scan_phase;

    bfdr_out_t panel_replies [$];
    plan_row_t plan [$];

    int  mismatches, replies_seen, items_sent, useful_items, directed_items;
    int  fills_seen, streams_done, cycle_count;
    int  burst_left, gap_left;
    bit  hold_off_req;

    banked_framebuffer_dirty_refresh_core #(
        .PANEL_COLUMNS(PANEL_COLUMNS),
        .PANEL_ROWS   (PANEL_ROWS),
        .PAGE_COUNT   (PAGE_COUNT)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    function automatic void grow_dirty(int c0, int r0, int c1, int r1);
        if (c0 < dirty_c_lo) dirty_c_lo = c0[6:0];
        if (c1 > dirty_c_hi) dirty_c_hi = c1[6:0];
        if (r0 < dirty_r_lo) dirty_r_lo = r0[5:0];
        if (r1 > dirty_r_hi) dirty_r_hi = r1[5:0];
    endfunction

    // applies one transaction to the panel copy and returns the reply it produces
    function automatic bfdr_out_t step_panel(bfdr_in_t t);
        bfdr_out_t r;
        int        pg, idx, clo, chi, rlo, rhi, first, lastp;
        bit        on_panel;
        logic [7:0] msk;
        r.kind      = KIND_NONE;
        r.out_value = 8'h00;
        r.pixel_bit = 1'b0;
        r.last      = 1'b0;
        pg       = t.row / ROWS_PER_PAGE;
        idx      = pg * PANEL_COLUMNS + t.col;
        on_panel = (t.col < PANEL_COLUMNS) && (t.row < PANEL_ROWS) && (pg < PAGE_COUNT);
        msk      = 8'h01 << (t.row % ROWS_PER_PAGE);
        case (t.op)
            OP_SET_PIXEL: begin
                if (on_panel) begin
                    if (t.pixel_on) frame_mem[idx] = frame_mem[idx] | msk;
                    else frame_mem[idx] = frame_mem[idx] & ~msk;
                end
            end
            OP_GET_PIXEL: begin
                if (on_panel) r.pixel_bit = |(frame_mem[idx] & msk);
            end
            OP_FILL: begin
                for (int i = 0; i < STORE_SIZE; i++) frame_mem[i] = t.fill_byte;
                grow_dirty(0, 0, PANEL_COLUMNS - 1, PANEL_ROWS - 1);
                fills_seen++;
            end
            OP_MARK_AREA: begin
                grow_dirty(t.col, t.row, t.col_end, t.row_end);
            end
            OP_START: begin
                clo = dirty_c_lo;
                chi = dirty_c_hi;
                rlo = dirty_r_lo;
                rhi = dirty_r_hi;
                dirty_c_lo = 7'(PANEL_COLUMNS - 1);
                dirty_c_hi = '0;
                dirty_r_lo = 6'(PANEL_ROWS - 1);
                dirty_r_hi = '0;
                scan_on    = 1'b0;
                scan_phase = PHASE_PAGE;
                if (chi > PANEL_COLUMNS - 1) chi = PANEL_COLUMNS - 1;
                first = rlo / ROWS_PER_PAGE;
                lastp = rhi / ROWS_PER_PAGE;
                if (lastp > PAGE_COUNT - 1) lastp = PAGE_COUNT - 1;
                if (!(clo > chi || first > lastp || rlo > rhi)) begin
                    scan_on       = 1'b1;
                    scan_lo       = clo;
                    scan_hi       = chi;
                    scan_page     = first;
                    scan_page_end = lastp;
                    scan_col      = clo;
                end
            end
            OP_NEXT_BYTE: begin
                if (scan_on) begin
                    case (scan_phase)
                        PHASE_PAGE: begin
                            r.kind      = KIND_PAGE;
                            r.out_value = scan_page[7:0];
                            scan_phase  = PHASE_COLUMN;
                        end
                        PHASE_COLUMN: begin
                            r.kind      = KIND_COLUMN;
                            r.out_value = scan_lo[7:0];
                            scan_phase  = PHASE_DATA;
                            scan_col    = scan_lo;
                        end
                        default: begin
                            r.kind      = KIND_DATA;
                            r.out_value = frame_mem[scan_page * PANEL_COLUMNS + scan_col];
                            if (scan_col >= scan_hi) begin
                                if (scan_page >= scan_page_end) begin
                                    r.last  = 1'b1;
                                    scan_on = 1'b0;
                                    streams_done++;
                                end else begin
                                    scan_page++;
                                    scan_phase = PHASE_PAGE;
                                end
                            end else begin
                                scan_col++;
                            end
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic plan_row_t mk_row(logic [2:0] op, int c, int r, int ce, int re, int pix,
                                         logic [7:0] fb, int typed, logic [1:0] kind,
                                         logic [7:0] val, int lst);
        plan_row_t p;
        p.item.op              = op;
        p.item.col             = c[6:0];
        p.item.row             = r[5:0];
        p.item.col_end         = ce[6:0];
        p.item.row_end         = re[5:0];
        p.item.pixel_on        = pix[0];
        p.item.fill_byte       = fb;
        p.typed                = (typed != 0);
        p.reply.kind           = kind;
        p.reply.out_value      = val;
        p.reply.pixel_bit      = 1'b0;
        p.reply.last           = lst[0];
        return p;
    endfunction

    function automatic bfdr_in_t rand_item();
        bfdr_in_t t;
        t.op        = OP_GET_PIXEL;
        t.col       = 7'($urandom_range(0, 127));
        t.row       = 6'($urandom_range(0, 63));
        t.col_end   = 7'($urandom_range(0, 127));
        t.row_end   = 6'($urandom_range(0, 63));
        t.pixel_on  = 1'($urandom_range(0, 1));
        t.fill_byte = 8'($urandom_range(0, 255));
        return t;
    endfunction

    // offers one transaction in the sender's burst pattern and books its reply on acceptance
    task automatic push_op(input bfdr_in_t t, input bit typed, input bfdr_out_t typed_reply);
        bfdr_out_t r;
        bit        useful;
        @(negedge aclk);
        while (gap_left > 0) begin
            s_valid <= 1'b0;
            gap_left--;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        useful = (t.op <= OP_NEXT_BYTE) && !(t.op == OP_NEXT_BYTE && !scan_on);
        r = step_panel(t);
        panel_replies.push_back(typed ? typed_reply : r);
        items_sent++;
        if (useful) useful_items++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                                      : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
    endtask

    // receiver: changing stall patterns, plus one long hold-off on request
    initial begin : receiver
        int mode, span;
        m_ready <= 1'b0;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                for (int k = 0; k < HOLD_OFF_CYCLES; k++) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            for (int k = 0; k < span; k++) begin
                @(negedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 7) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : reply_check
        bfdr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            replies_seen++;
            if (panel_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected reply: kind %0d value %02h bit %0d last %0d",
                             m_data.kind, m_data.out_value, m_data.pixel_bit, m_data.last);
            end else begin
                want = panel_replies.pop_front();
                if (m_data.kind !== want.kind || m_data.out_value !== want.out_value ||
                    m_data.pixel_bit !== want.pixel_bit || m_data.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("reply %0d mismatch: exp kind %0d value %02h bit %0d last %0d",
                                 replies_seen, want.kind, want.out_value, want.pixel_bit,
                                 want.last);
                        $display("    got kind %0d value %02h bit %0d last %0d",
                                 m_data.kind, m_data.out_value, m_data.pixel_bit,
                                 m_data.last);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
                 panel_replies.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        bfdr_in_t   t;
        bfdr_out_t  no_reply;
        logic [2:0] noise_ops [6];
        int         sel, n, pulls;
        bit         full_pull_done;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        hold_off_req = 1'b0;
        no_reply     = '0;
        mismatches   = 0;
        replies_seen = 0;
        items_sent   = 0;
        useful_items = 0;
        fills_seen   = 0;
        streams_done = 0;
        burst_left   = 1;
        gap_left     = 0;
        full_pull_done = 1'b0;
        noise_ops    = '{OP_SET_PIXEL, OP_GET_PIXEL, OP_START, OP_NEXT_BYTE, OP_SPARE_6,
                         OP_SPARE_7};

        for (int i = 0; i < STORE_SIZE; i++) frame_mem[i] = 8'h00;
        dirty_c_lo = '0;
        dirty_c_hi = '0;
        dirty_r_lo = '0;
        dirty_r_hi = '0;
        scan_on    = 1'b0;
        scan_phase = PHASE_PAGE;

        //                  op            col  row  ce   re  on fill  typed kind         val  last
        plan.push_back(mk_row(OP_GET_PIXEL,   0,   0,   0,   0, 0, 8'h00, 1, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_NEXT_BYTE,   0,   0,   0,   0, 0, 8'h00, 1, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_SET_PIXEL,   0,   0,   0,   0, 1, 8'h00, 0, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_SET_PIXEL,  83,  47,   0,   0, 1, 8'h00, 0, KIND_NONE,   8'h00, 0));
        // off-panel writes are dropped
        plan.push_back(mk_row(OP_SET_PIXEL, 127,  63,   0,   0, 1, 8'h00, 0, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_SET_PIXEL,  84,   0,   0,   0, 1, 8'h00, 0, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_GET_PIXEL,   0,   0,   0,   0, 0, 8'h00, 0, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_GET_PIXEL,  83,  47,   0,   0, 0, 8'h00, 0, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_GET_PIXEL, 127,  63,   0,   0, 0, 8'h00, 1, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_GET_PIXEL,   0,  48,   0,   0, 0, 8'h00, 1, KIND_NONE,   8'h00, 0));
        // dirty area from reset is the single byte at page 0, column 0
        plan.push_back(mk_row(OP_START,       0,   0,   0,   0, 0, 8'h00, 1, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_NEXT_BYTE,   0,   0,   0,   0, 0, 8'h00, 1, KIND_PAGE,   8'h00, 0));
        plan.push_back(mk_row(OP_NEXT_BYTE,   0,   0,   0,   0, 0, 8'h00, 1, KIND_COLUMN, 8'h00, 0));
        plan.push_back(mk_row(OP_NEXT_BYTE,   0,   0,   0,   0, 0, 8'h00, 1, KIND_DATA,   8'h01, 1));
        // max edges beyond the panel saturate to the last page and column
        plan.push_back(mk_row(OP_MARK_AREA, 127,  63, 127,  63, 0, 8'h00, 1, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_START,       0,   0,   0,   0, 0, 8'h00, 1, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_NEXT_BYTE,   0,   0,   0,   0, 0, 8'h00, 0, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_NEXT_BYTE,   0,   0,   0,   0, 0, 8'h00, 0, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_NEXT_BYTE,   0,   0,   0,   0, 0, 8'h00, 0, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_SET_PIXEL,   0,   0,   0,   0, 0, 8'h00, 0, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_GET_PIXEL,   0,   0,   0,   0, 0, 8'h00, 0, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_FILL,        0,   0,   0,   0, 0, 8'hFF, 1, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_GET_PIXEL,   5,   5,   0,   0, 0, 8'h00, 0, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_SPARE_6,     0,   0,   0,   0, 0, 8'h00, 1, KIND_NONE,   8'h00, 0));
        // second start abandons the full-panel refresh and finds an empty area
        plan.push_back(mk_row(OP_START,       0,   0,   0,   0, 0, 8'h00, 1, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_NEXT_BYTE,   0,   0,   0,   0, 0, 8'h00, 0, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_START,       0,   0,   0,   0, 0, 8'h00, 1, KIND_NONE,   8'h00, 0));
        plan.push_back(mk_row(OP_NEXT_BYTE,   0,   0,   0,   0, 0, 8'h00, 1, KIND_NONE,   8'h00, 0));

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) push_op(plan[i].item, plan[i].typed, plan[i].reply);
        directed_items = items_sent;
        useful_items   = 0;

        // long receiver stall while the sender keeps offering
        hold_off_req = 1'b1;

        while (useful_items < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                // draw, mark a small area, refresh it and pull it out
                n = $urandom_range(0, 6);
                for (int k = 0; k < n; k++) begin
                    t     = rand_item();
                    t.op  = OP_SET_PIXEL;
                    t.col = 7'($urandom_range(0, PANEL_COLUMNS - 1));
                    t.row = 6'($urandom_range(0, PANEL_ROWS - 1));
                    push_op(t, 1'b0, no_reply);
                end
                t    = rand_item();
                t.op = OP_MARK_AREA;
                if ($urandom_range(0, 32) != 0) begin
                    t.col     = 7'($urandom_range(0, PANEL_COLUMNS - 1));
                    t.row     = 6'($urandom_range(0, PANEL_ROWS - 1));
                    t.col_end = 7'(t.col + $urandom_range(0, 15));
                    t.row_end = 6'(t.row + $urandom_range(0, 15));
                end
                push_op(t, 1'b0, no_reply);
                t    = rand_item();
                t.op = OP_START;
                push_op(t, 1'b0, no_reply);
                while (scan_on) begin
                    sel = $urandom_range(0, 99);
                    t   = rand_item();
                    if (sel < 92) begin
                        t.op = OP_NEXT_BYTE;
                    end else if (sel < 99) begin
                        t.op  = ($urandom_range(0, 1) != 0) ? OP_SET_PIXEL : OP_GET_PIXEL;
                        t.col = 7'($urandom_range(0, PANEL_COLUMNS - 1));
                        t.row = 6'($urandom_range(0, PANEL_ROWS - 1));
                    end else begin
                        t.op = OP_START;
                    end
                    push_op(t, 1'b0, no_reply);
                end
                if ($urandom_range(0, 3) == 0) begin
                    t    = rand_item();
                    t.op = OP_NEXT_BYTE;
                    push_op(t, 1'b0, no_reply);
                end
            end else if (sel < 63) begin
                // fill, then pull part of the full-panel refresh (all of it the first time)
                t    = rand_item();
                t.op = OP_FILL;
                push_op(t, 1'b0, no_reply);
                t.op = OP_START;
                push_op(t, 1'b0, no_reply);
                pulls = full_pull_done ? $urandom_range(0, 40) : STORE_SIZE * 2;
                full_pull_done = 1'b1;
                for (int k = 0; k < pulls && scan_on; k++) begin
                    t    = rand_item();
                    t.op = OP_NEXT_BYTE;
                    push_op(t, 1'b0, no_reply);
                end
            end else if (sel < 80) begin
                t    = rand_item();
                t.op = noise_ops[$urandom_range(0, 5)];
                push_op(t, 1'b0, no_reply);
            end else if (sel < 90) begin
                t    = rand_item();
                t.op = ($urandom_range(0, 1) != 0) ? OP_SET_PIXEL : OP_GET_PIXEL;
                push_op(t, 1'b0, no_reply);
            end else begin
                // random area, refresh cut short
                t    = rand_item();
                t.op = OP_MARK_AREA;
                push_op(t, 1'b0, no_reply);
                t.op = OP_START;
                push_op(t, 1'b0, no_reply);
                pulls = $urandom_range(0, 20);
                for (int k = 0; k < pulls && scan_on; k++) begin
                    t    = rand_item();
                    t.op = OP_NEXT_BYTE;
                    push_op(t, 1'b0, no_reply);
                end
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (panel_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d transactions sent (%0d from the directed table), %0d replies checked",
                 items_sent, directed_items, replies_seen);
        $display("%0d fills, %0d refresh streams pulled to the final byte, %0d mismatches",
                 fills_seen, streams_done, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
